@@ hdl/stt_pkg.sv @@
// Package for the source text tokenizer: token kinds, scan modes and character classes.
package stt_pkg;

  localparam int SOURCE_OFFSET_BITS_DEF = 16;
  localparam int MAX_TOKEN_LENGTH_DEF   = 255;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_DOT     = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_INT     = 5'd2;
  localparam logic [4:0] K_REAL    = 5'd3;
  localparam logic [4:0] K_IF      = 5'd4;
  localparam logic [4:0] K_DEF     = 5'd5;
  localparam logic [4:0] K_RETURN  = 5'd6;
  localparam logic [4:0] K_PUNCT0  = 5'd7;
  localparam logic [4:0] K_UNKNOWN = 5'd26;

  typedef struct packed {
    logic [7:0]  length;
    logic [15:0] start_offset;
    logic [15:0] line;
    logic [4:0]  kind;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h3D:   k = K_PUNCT0 + 5'd0;   // =
      8'h2C:   k = K_PUNCT0 + 5'd1;   // ,
      8'h3B:   k = K_PUNCT0 + 5'd2;   // ;
      8'h2B:   k = K_PUNCT0 + 5'd3;   // +
      8'h2D:   k = K_PUNCT0 + 5'd4;   // -
      8'h2F:   k = K_PUNCT0 + 5'd5;   // /
      8'h25:   k = K_PUNCT0 + 5'd6;   // %
      8'h2A:   k = K_PUNCT0 + 5'd7;   // *
      8'h21:   k = K_PUNCT0 + 5'd8;   // !
      8'h28:   k = K_PUNCT0 + 5'd9;   // (
      8'h29:   k = K_PUNCT0 + 5'd10;  // )
      8'h5B:   k = K_PUNCT0 + 5'd11;  // [
      8'h5D:   k = K_PUNCT0 + 5'd12;  // ]
      8'h7B:   k = K_PUNCT0 + 5'd13;  // {
      8'h7D:   k = K_PUNCT0 + 5'd14;  // }
      8'h3C:   k = K_PUNCT0 + 5'd15;  // <
      8'h3E:   k = K_PUNCT0 + 5'd16;  // >
      8'h7C:   k = K_PUNCT0 + 5'd17;  // |
      8'h26:   k = K_PUNCT0 + 5'd18;  // &
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/source_text_tokenizer.sv @@
// Source text tokenizer: turns a stream of ASCII characters into tokens.
//
// The input channel takes one character per beat in in_tdata; in_tuser set
// means the beat carries no character and ends the source, as does a NUL.
// Each token leaves on the output channel as one beat with its kind, line,
// start offset and length; out_tlast marks the final token caused by an
// input beat. An input beat causes zero, one or two tokens.
// The character is scanned in the cycle it is accepted, and its tokens show
// on the output in the cycle after. An input beat that causes at most one
// token is taken every cycle while the receiver is ready; a beat that causes
// two holds the input until its first token has been taken. The two-entry
// result buffer is what sets this rate.
// Reset clears the scanner to idle at line 1, offset 0, and empties the result
// buffer. When the receiver stalls, results wait in the buffer and in_tready
// drops once the buffer cannot take the tokens of another character.
module source_text_tokenizer #(
  parameter int SOURCE_OFFSET_BITS = stt_pkg::SOURCE_OFFSET_BITS_DEF,
  parameter int MAX_TOKEN_LENGTH   = stt_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tuser,   // end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // kind, line, start_offset, length, zero fill
  output logic        out_tlast
);
  import stt_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);

  logic [2:0]                    mode_r, mode_nxt;
  logic                          dot_r, dot_nxt;
  logic [15:0]                   line_r, line_nxt;
  logic [SOURCE_OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [SOURCE_OFFSET_BITS-1:0] beg_r, beg_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          tl_r, tl_nxt;
  logic [7:0]                    kw_r [6];

  logic       kw_wr;
  logic [2:0] kw_idx;

  token_t q_r [2];
  logic   qlast_r [2];
  logic [1:0] qcnt_r;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       is_end;
  logic       do_flush, do_scan, do_ext;
  logic       fl_v, sc_v;
  token_t     fl_tok, sc_tok, r0, r1;
  logic [4:0] fl_kind;
  logic [7:0] len_sat;
  logic [1:0] n_res;

  assign c      = in_tdata;
  assign is_end = in_tuser || (c == 8'h00);
  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (qcnt_r == 2'd0) || ((qcnt_r == 2'd1) && out_tready);

  assign len_sat = (32'(cnt_r) > 32'd255) ? 8'hFF : 8'(cnt_r);

  always_comb begin
    fl_kind = K_IDENT;
    if (mode_r == MODE_NUMBER) begin
      fl_kind = dot_r ? K_REAL : K_INT;
    end else if (mode_r == MODE_DOT) begin
      fl_kind = K_UNKNOWN;
    end else if (!tl_r) begin
      if ((32'(cnt_r) == 32'd2) && (kw_r[0] == 8'h69) && (kw_r[1] == 8'h66)) begin
        fl_kind = K_IF;
      end else if ((32'(cnt_r) == 32'd3) && (kw_r[0] == 8'h64) && (kw_r[1] == 8'h65)
                   && (kw_r[2] == 8'h66)) begin
        fl_kind = K_DEF;
      end else if ((32'(cnt_r) == 32'd6) && (kw_r[0] == 8'h72) && (kw_r[1] == 8'h65)
                   && (kw_r[2] == 8'h74) && (kw_r[3] == 8'h75) && (kw_r[4] == 8'h72)
                   && (kw_r[5] == 8'h6E)) begin
        fl_kind = K_RETURN;
      end
    end
    fl_tok.kind         = fl_kind;
    fl_tok.line         = line_r;
    fl_tok.start_offset = 16'(beg_r);
    fl_tok.length       = (mode_r == MODE_DOT) ? 8'd1 : len_sat;
  end

  always_comb begin
    mode_nxt = mode_r;
    dot_nxt  = dot_r;
    line_nxt = line_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    cnt_nxt  = cnt_r;
    tl_nxt   = tl_r;
    kw_wr    = 1'b0;
    kw_idx   = 3'd0;
    do_flush = 1'b0;
    do_scan  = 1'b0;
    do_ext   = 1'b0;
    sc_v     = 1'b0;
    sc_tok.kind         = punct_kind(c);
    sc_tok.line         = line_r;
    sc_tok.start_offset = 16'(pos_r);
    sc_tok.length       = 8'd1;

    if (is_end) begin
      do_flush = 1'b1;
    end else begin
      pos_nxt = pos_r + SOURCE_OFFSET_BITS'(1);
      unique case (mode_r)
        MODE_COMMENT: begin
          if (c == 8'h0A) begin
            mode_nxt = MODE_IDLE;
            if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          end
        end
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            do_ext = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_scan  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            do_ext = 1'b1;
          end else if ((c == 8'h2E) && !dot_r) begin
            dot_nxt = 1'b1;
            do_ext  = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_scan  = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(c)) begin
            mode_nxt = MODE_NUMBER;
            do_ext   = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_scan  = 1'b1;
          end
        end
        default: begin
          do_scan = 1'b1;
        end
      endcase
    end

    fl_v = do_flush && ((mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER)
                        || (mode_r == MODE_DOT));
    if (do_flush) begin
      mode_nxt = MODE_IDLE;
      dot_nxt  = 1'b0;
    end

    if (do_ext) begin
      if (32'(cnt_r) < 32'd6) begin
        kw_wr  = 1'b1;
        kw_idx = cnt_r[2:0];
      end else begin
        tl_nxt = 1'b1;
      end
      if (cnt_r < CNT_W'(MAX_TOKEN_LENGTH)) cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (do_scan) begin
      mode_nxt = MODE_IDLE;
      if ((c == 8'h20) || (c == 8'h09) || (c == 8'h0D)) begin
        mode_nxt = MODE_IDLE;
      end else if (c == 8'h0A) begin
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
      end else if (c == 8'h23) begin
        mode_nxt = MODE_COMMENT;
      end else if (is_letter(c) || is_digit(c) || (c == 8'h2E)) begin
        if (is_letter(c)) begin
          mode_nxt = MODE_IDENT;
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUMBER;
        end else begin
          mode_nxt = MODE_DOT;
        end
        beg_nxt = pos_r;
        cnt_nxt = CNT_W'(1);
        dot_nxt = (c == 8'h2E);
        tl_nxt  = 1'b0;
        kw_wr   = 1'b1;
        kw_idx  = 3'd0;
      end else begin
        sc_v = 1'b1;
      end
    end

    if (is_end) begin
      sc_v                = 1'b1;
      sc_tok.kind         = K_END;
      sc_tok.start_offset = 16'(pos_r);
      sc_tok.length       = 8'd0;
    end

    r0    = fl_v ? fl_tok : sc_tok;
    r1    = sc_tok;
    n_res = {1'b0, fl_v} + {1'b0, sc_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dot_r  <= 1'b0;
      line_r <= 16'd1;
      pos_r  <= '0;
      beg_r  <= '0;
      cnt_r  <= '0;
      tl_r   <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      cnt_r  <= cnt_nxt;
      tl_r   <= tl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && kw_wr) begin
      kw_r[kw_idx] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= 2'd0;
    end else if (in_acc) begin
      qcnt_r <= n_res;
    end else if (out_acc) begin
      qcnt_r <= qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[0]     <= r0;
      q_r[1]     <= r1;
      qlast_r[0] <= (n_res == 2'd1);
      qlast_r[1] <= 1'b1;
    end else if (out_acc) begin
      q_r[0]     <= q_r[1];
      qlast_r[0] <= qlast_r[1];
    end
  end

  assign out_tvalid = (qcnt_r != 2'd0);
  assign out_tdata  = {3'b000, q_r[0]};
  assign out_tlast  = qlast_r[0];

endmodule

@@ tb/tb_source_text_tokenizer.sv @@
// Self-checking testbench for source_text_tokenizer with a built-in token predictor.
module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [7:0] TAB = 8'h09;
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] NUL = 8'h00;

  typedef struct packed {
    logic last;
    token_t tok;
  } token_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tlast;

  source_text_tokenizer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  string punct_list = "=,;+-/%*!()[]{}<>|&";

  logic [2:0] mode_q = MODE_IDLE;
  logic dot_q = 1'b0;
  logic [15:0] line_q = 16'd1;
  logic [15:0] pos_q = 16'd0;
  logic [15:0] begin_q = 16'd0;
  logic [7:0] count_q = 8'd0;
  logic [7:0] kw_q [6];
  logic too_long_q = 1'b0;

  token_beat_t step_tokens[$];
  token_beat_t expected_tokens[$];

  int items_sent = 0;
  int tokens_checked = 0;
  int end_tokens = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] c);
    for (int i = 0; i < 19; i++) begin
      if (punct_list[i] == c) return K_PUNCT0 + 5'(i);
    end
    return K_UNKNOWN;
  endfunction

  function automatic void emit_token(input logic [4:0] kind, input logic [15:0] start,
                                     input logic [7:0] len);
    token_beat_t b;
    b.last = 1'b0;
    b.tok.kind = kind;
    b.tok.line = line_q;
    b.tok.start_offset = start;
    b.tok.length = len;
    step_tokens.push_back(b);
  endfunction

  function automatic void open_token(input logic [2:0] m, input logic [7:0] c);
    mode_q = m;
    begin_q = pos_q;
    count_q = 8'd1;
    dot_q = (c == ".");
    too_long_q = 1'b0;
    kw_q[0] = c;
  endfunction

  function automatic void grow_token(input logic [7:0] c);
    if (count_q < 8'd6) begin
      kw_q[count_q] = c;
    end else begin
      too_long_q = 1'b1;
    end
    if (count_q < MAX_TOKEN_LENGTH_DEF) count_q = count_q + 8'd1;
  endfunction

  function automatic void flush_pending();
    logic [4:0] kind;
    kind = K_IDENT;
    if (mode_q == MODE_IDENT) begin
      if (!too_long_q) begin
        if (count_q == 8'd2 && {kw_q[0], kw_q[1]} == "if") kind = K_IF;
        else if (count_q == 8'd3 && {kw_q[0], kw_q[1], kw_q[2]} == "def") kind = K_DEF;
        else if (count_q == 8'd6 &&
                 {kw_q[0], kw_q[1], kw_q[2], kw_q[3], kw_q[4], kw_q[5]} == "return")
          kind = K_RETURN;
      end
      emit_token(kind, begin_q, count_q);
    end else if (mode_q == MODE_NUMBER) begin
      emit_token(dot_q ? K_REAL : K_INT, begin_q, count_q);
    end else if (mode_q == MODE_DOT) begin
      emit_token(K_UNKNOWN, begin_q, 8'd1);
    end
    mode_q = MODE_IDLE;
    dot_q = 1'b0;
  endfunction

  function automatic void scan_fresh(input logic [7:0] c);
    if (c == " " || c == TAB || c == CR) begin
    end else if (c == LF) begin
      if (line_q != 16'hFFFF) line_q = line_q + 16'd1;
    end else if (c == "#") begin
      mode_q = MODE_COMMENT;
    end else if (is_alpha(c)) begin
      open_token(MODE_IDENT, c);
    end else if (is_num(c)) begin
      open_token(MODE_NUMBER, c);
    end else if (c == ".") begin
      open_token(MODE_DOT, c);
    end else begin
      emit_token(punct_code(c), pos_q, 8'd1);
    end
  endfunction

  function automatic void predict_item(input logic [7:0] c, input logic eos);
    step_tokens.delete();
    if (eos || c == NUL) begin
      flush_pending();
      emit_token(K_END, pos_q, 8'd0);
    end else begin
      case (mode_q)
        MODE_COMMENT: begin
          if (c == LF) begin
            mode_q = MODE_IDLE;
            if (line_q != 16'hFFFF) line_q = line_q + 16'd1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_num(c)) begin
            grow_token(c);
          end else begin
            flush_pending();
            scan_fresh(c);
          end
        end
        MODE_NUMBER: begin
          if (is_num(c)) begin
            grow_token(c);
          end else if (c == "." && !dot_q) begin
            dot_q = 1'b1;
            grow_token(c);
          end else begin
            flush_pending();
            scan_fresh(c);
          end
        end
        MODE_DOT: begin
          if (is_num(c)) begin
            mode_q = MODE_NUMBER;
            grow_token(c);
          end else begin
            flush_pending();
            scan_fresh(c);
          end
        end
        default: begin
          mode_q = MODE_IDLE;
          scan_fresh(c);
        end
      endcase
      pos_q = pos_q + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 1) == 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      in_tuser <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eos;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_item(c, eos);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic wait_for_tokens();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_keywords();
    send_text("if def return returns Return ifx de");
    send_char(8'h5A, 1'b1);
    wait_for_tokens();
  endtask

  task automatic test_numbers_and_dots();
    send_text("1.2.3 .5 .x 7.");
    send_char(NUL, 1'b0);
    wait_for_tokens();
  endtask

  task automatic test_comments_and_spacing();
    send_text("a#b c");
    send_char(LF, 1'b0);
    send_char(TAB, 1'b0);
    send_char(CR, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("@x#z");
    send_char(8'h00, 1'b1);
    wait_for_tokens();
  endtask

  task automatic test_punctuators();
    int i;
    for (i = 0; i < 19; i++) send_char(punct_list[i], 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hA5, 1'b1);
    wait_for_tokens();
  endtask

  task automatic test_long_tokens();
    send_char("r", 1'b0);
    repeat (299) send_char(rand_letter(), 1'b0);
    send_char(" ", 1'b0);
    repeat (150) send_char(rand_digit(), 1'b0);
    send_char(".", 1'b0);
    repeat (150) send_char(rand_digit(), 1'b0);
    send_char(NUL, 1'b0);
    wait_for_tokens();
  endtask

  task automatic send_fragment();
    int r;
    int n;
    int i;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send_char(rand_letter(), 1'b0);
      n = $urandom_range(0, 7);
      for (i = 0; i < n; i++)
        send_char(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter(), 1'b0);
    end else if (r < 28) begin
      case ($urandom_range(0, 2))
        0: send_text("if");
        1: send_text("def");
        default: send_text("return");
      endcase
      if ($urandom_range(0, 3) == 0) send_char(rand_letter(), 1'b0);
    end else if (r < 40) begin
      if ($urandom_range(0, 4) == 0) send_char(".", 1'b0);
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) send_char(rand_digit(), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        send_char(".", 1'b0);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) send_char(rand_digit(), 1'b0);
      end
    end else if (r < 55) begin
      send_char(punct_list[$urandom_range(0, 18)], 1'b0);
    end else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: send_char(" ", 1'b0);
        1: send_char(TAB, 1'b0);
        2: send_char(CR, 1'b0);
        default: send_char(LF, 1'b0);
      endcase
    end else if (r < 76) begin
      send_char("#", 1'b0);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) send_char(8'($urandom_range(32, 126)), 1'b0);
      if ($urandom_range(0, 3) != 0) send_char(LF, 1'b0);
    end else if (r < 82) begin
      send_char(".", 1'b0);
    end else if (r < 92) begin
      send_char(8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 96) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_char(NUL, 1'b0);
    end
  endtask

  task automatic test_random_source();
    int first_item;
    int fragments;
    first_item = items_sent;
    fragments = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (fragments % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_fragment();
      fragments++;
    end
    quiet = 1'b0;
    send_char(8'h00, 1'b1);
    wait_for_tokens();
  endtask

  task automatic test_line_counting();
    repeat (40) send_char(LF, 1'b0);
    send_text("x 1 =");
    send_char(LF, 1'b0);
    send_text("y");
    send_char(NUL, 1'b0);
    wait_for_tokens();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t got;
    token_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[44:0];
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d: none expected, got kind %0d line %0d start %0d length %0d",
                   tokens_checked, got.kind, got.line, got.start_offset, got.length);
      end else begin
        want = expected_tokens.pop_front();
        if (want.tok.kind == K_END) end_tokens++;
        if (got.kind != want.tok.kind || got.line != want.tok.line ||
            got.start_offset != want.tok.start_offset || got.length != want.tok.length ||
            out_tlast != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token %0d: expected kind %0d line %0d start %0d length %0d last %0b,",
                      " got kind %0d line %0d start %0d length %0d last %0b"},
                     tokens_checked, want.tok.kind, want.tok.line, want.tok.start_offset,
                     want.tok.length, want.last, got.kind, got.line, got.start_offset,
                     got.length, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("source_text_tokenizer regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_keywords();
    test_numbers_and_dots();
    test_comments_and_spacing();
    test_punctuators();
    test_long_tokens();
    test_random_source();
    test_line_counting();
    $display("Sent %0d input beats; compared %0d token beats, %0d of them end tokens.",
             items_sent, tokens_checked, end_tokens);
    $display("Mismatches: %0d; tokens still outstanding: %0d.",
             mismatches, expected_tokens.size());
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("source_text_tokenizer regression: pass");
    end else begin
      $display("source_text_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
